// File: rtl/core/segvar_pkg.sv
// Shared widths, register indexes and divider request types for the segment variance block.
package segvar_pkg;

  localparam int COORD_W      = 16;
  localparam int MAX_SEGMENTS = 1024;
  localparam int NUM_AXES     = 3;
  localparam int AXIS_W       = 2;

  localparam int WEIGHT_W   = 32;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEG_COUNT = CFG_IDX_W'(1);

  // Datapath widths: d is Q8.8, sq and fourth power are Q16.16
  localparam int DELTA_W = COORD_W + 1;
  localparam int DMAG_W  = COORD_W;
  localparam int SQ_W    = 2 * COORD_W + 2;
  localparam int TERM_W  = SQ_W + COORD_W + 1;
  localparam int T_W     = TERM_W + 1;
  localparam int MAG_W   = TERM_W;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 64;
  localparam int ACC_W  = SUM_W + WEIGHT_W;
  localparam int GRAD_W = 64;
  localparam int COST_W = 63;

  localparam int FRAC_SHIFT = 16;
  // gradient scale is weight * 4 / 2^24
  localparam int GRAD_SHIFT = 22;

  localparam int DIV_W      = ACC_W - FRAC_SHIFT;
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
  localparam int REM_W      = $clog2(MAX_SEGMENTS);

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] divisor;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/core/segment_length_variance_gradient.sv
// Top level: segment length variance cost and per-point gradient over a point stream.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_coord_x, in_coord_y, in_coord_z
//  out      output     out_valid / out_ready  out_point_index, out_grad_x/y/z,
//                                             out_cost_value, out_final_res
//  cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// A point is accepted only in idle; in_ready stays low until its result is loaded, and
// after the last point of a set until the cost is loaded; the first point is only stored.
// The single 34x34 multiplier and the iterative divider are shared by all three axes.
// Reset is synchronous: weight 0, segment count 1, set state cleared.
// A result waits in the output register; the sequencer holds only when it must load
// a new result while the previous one is still not taken.
module segment_length_variance_gradient (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [segvar_pkg::COORD_W-1:0]   in_coord_x,
  input  logic signed [segvar_pkg::COORD_W-1:0]   in_coord_y,
  input  logic signed [segvar_pkg::COORD_W-1:0]   in_coord_z,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic        [segvar_pkg::CNT_W-1:0]     out_point_index,
  output logic signed [segvar_pkg::GRAD_W-1:0]    out_grad_x,
  output logic signed [segvar_pkg::GRAD_W-1:0]    out_grad_y,
  output logic signed [segvar_pkg::GRAD_W-1:0]    out_grad_z,
  output logic        [segvar_pkg::COST_W-1:0]    out_cost_value,
  output logic                                    out_final_res,
  input  logic                                    cfg_wr_en,
  input  logic        [segvar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [segvar_pkg::CFG_DATA_W-1:0] cfg_data
);
  import segvar_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE     = 13'h0001,
    ST_SQ_MUL   = 13'h0002,
    ST_SQ_ADD   = 13'h0004,
    ST_Q_MUL    = 13'h0008,
    ST_Q_ADD    = 13'h0010,
    ST_T_MUL    = 13'h0020,
    ST_T_ADD    = 13'h0040,
    ST_LAST_SEL = 13'h0080,
    ST_SC_LO    = 13'h0100,
    ST_SC_HI    = 13'h0200,
    ST_SC_ADD   = 13'h0400,
    ST_SC_WAIT  = 13'h0800,
    ST_EMIT     = 13'h1000
  } state_t;

  typedef enum logic [1:0] {
    PH_GRAD = 2'd0,
    PH_LAST = 2'd1,
    PH_COST = 2'd2
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [AXIS_W-1:0]   k_r, k_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [CNT_W-1:0]    seg_count_r, seg_count_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    qsum_r, qsum_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [SUM_W-1:0]    src_r, src_nxt;
  logic                neg_r, neg_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [COST_W-1:0]   cost_r, cost_nxt;

  logic signed [COORD_W-1:0] prev_point_r [NUM_AXES];
  logic signed [COORD_W-1:0] prev_point_nxt [NUM_AXES];
  logic signed [DELTA_W-1:0] delta_r [NUM_AXES];
  logic signed [DELTA_W-1:0] delta_nxt [NUM_AXES];
  logic signed [TERM_W-1:0]  prev_term_r [NUM_AXES];
  logic signed [TERM_W-1:0]  prev_term_nxt [NUM_AXES];
  logic signed [TERM_W-1:0]  cur_term_r [NUM_AXES];
  logic signed [TERM_W-1:0]  cur_term_nxt [NUM_AXES];
  logic signed [GRAD_W-1:0]  grad_r [NUM_AXES];
  logic signed [GRAD_W-1:0]  grad_nxt [NUM_AXES];

  logic                      out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]          out_index_r, out_index_nxt;
  logic signed [GRAD_W-1:0]  out_grad_r [NUM_AXES];
  logic signed [GRAD_W-1:0]  out_grad_nxt [NUM_AXES];
  logic [COST_W-1:0]         out_cost_r, out_cost_nxt;
  logic                      out_final_r, out_final_nxt;

  logic signed [COORD_W-1:0] in_pt [NUM_AXES];
  logic                      in_acc;
  logic                      out_free;
  logic [CNT_W-1:0]          n_eff;
  logic signed [DELTA_W-1:0] dsel;
  logic [DELTA_W-1:0]        dabs_full;
  logic [DMAG_W-1:0]         dabs;
  logic [MUL_W-1:0]          mul_a;
  logic [MUL_W-1:0]          mul_b;
  logic [SUM_W:0]            qsum_add;
  logic signed [TERM_W-1:0]  cur_pos;
  logic signed [TERM_W-1:0]  cur_new;
  logic signed [T_W-1:0]     t_val;
  logic [T_W-1:0]            t_abs;
  logic [ACC_W-1:0]          acc_sum;
  logic [GRAD_W-1:0]         quo_g;
  logic [GRAD_W-1:0]         grad_val;
  logic [COST_W-1:0]         cost_val;

  div_req_t div_req;
  div_rsp_t div_rsp;

  segvar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_pt[0] = in_coord_x;
  assign in_pt[1] = in_coord_y;
  assign in_pt[2] = in_coord_z;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Zero count means one segment; clamp at the largest supported set
  always_comb begin
    if (seg_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (seg_count_r > CNT_W'(MAX_SEGMENTS)) begin
      n_eff = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_eff = seg_count_r;
    end
  end

  assign dsel      = delta_r[k_r];
  assign dabs_full = dsel[DELTA_W-1] ? (DELTA_W'(0) - dsel) : dsel;
  assign dabs      = dabs_full[DMAG_W-1:0];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ_MUL: begin
        mul_a = MUL_W'(dabs);
        mul_b = MUL_W'(dabs);
      end
      ST_Q_MUL: begin
        mul_a = MUL_W'(sq_r);
        mul_b = MUL_W'(sq_r);
      end
      ST_T_MUL: begin
        mul_a = MUL_W'(sq_r);
        mul_b = MUL_W'(dabs);
      end
      ST_SC_LO: begin
        mul_a = src_r[MUL_W-1:0];
        mul_b = MUL_W'(weight_r);
      end
      ST_SC_HI: begin
        mul_a = MUL_W'(src_r[SUM_W-1:MUL_W]);
        mul_b = MUL_W'(weight_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  assign qsum_add = {1'b0, qsum_r} + (SUM_W + 1)'(prod_r[PROD_W-1:FRAC_SHIFT]);
  assign cur_pos  = {1'b0, prod_r[TERM_W-2:0]};
  assign cur_new  = dsel[DELTA_W-1] ? (TERM_W'(0) - cur_pos) : cur_pos;

  always_comb begin
    if (state_r == ST_LAST_SEL) begin
      t_val = {cur_term_r[k_r][TERM_W-1], cur_term_r[k_r]};
    end else begin
      t_val = {prev_term_r[k_r][TERM_W-1], prev_term_r[k_r]}
            - {cur_new[TERM_W-1], cur_new};
    end
  end
  assign t_abs = t_val[T_W-1] ? (T_W'(0) - t_val) : t_val;

  assign acc_sum = acc_r + {prod_r[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};

  assign div_req.start    = (state_r == ST_SC_ADD);
  assign div_req.divisor  = n_eff;
  assign div_req.dividend = (phase_r == PH_COST) ? DIV_W'(acc_sum >> FRAC_SHIFT)
                                                 : DIV_W'(acc_sum >> GRAD_SHIFT);

  assign quo_g    = div_rsp.quotient[GRAD_W-1:0];
  assign grad_val = neg_r ? (GRAD_W'(0) - quo_g) : quo_g;
  assign cost_val = (|div_rsp.quotient[DIV_W-1:COST_W]) ? COST_MAX
                                                         : div_rsp.quotient[COST_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    k_nxt          = k_r;
    weight_nxt     = weight_r;
    seg_count_nxt  = seg_count_r;
    cnt_nxt        = cnt_r;
    qsum_nxt       = qsum_r;
    sq_nxt         = sq_r;
    src_nxt        = src_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    cost_nxt       = cost_r;
    prev_point_nxt = prev_point_r;
    delta_nxt      = delta_r;
    prev_term_nxt  = prev_term_r;
    cur_term_nxt   = cur_term_r;
    grad_nxt       = grad_r;
    out_valid_nxt  = out_valid_r;
    out_index_nxt  = out_index_r;
    out_grad_nxt   = out_grad_r;
    out_cost_nxt   = out_cost_r;
    out_final_nxt  = out_final_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WEIGHT:    weight_nxt    = cfg_data[WEIGHT_W-1:0];
        REG_SEG_COUNT: seg_count_nxt = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            prev_point_nxt[a] = in_pt[a];
            delta_nxt[a] = {in_pt[a][COORD_W-1], in_pt[a]}
                         - {prev_point_r[a][COORD_W-1], prev_point_r[a]};
          end
          if (cnt_r == '0) begin
            // first point of a set: store only
            cnt_nxt = CNT_W'(1);
          end else begin
            sq_nxt    = '0;
            k_nxt     = '0;
            phase_nxt = PH_GRAD;
            state_nxt = ST_SQ_MUL;
          end
        end
      end
      ST_SQ_MUL: state_nxt = ST_SQ_ADD;
      ST_SQ_ADD: begin
        sq_nxt = sq_r + prod_r[SQ_W-1:0];
        if (k_r == AXIS_W'(NUM_AXES - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_Q_MUL;
        end else begin
          k_nxt     = k_r + AXIS_W'(1);
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_Q_MUL: state_nxt = ST_Q_ADD;
      ST_Q_ADD: begin
        qsum_nxt  = qsum_add[SUM_W] ? '1 : qsum_add[SUM_W-1:0];
        state_nxt = ST_T_MUL;
      end
      ST_T_MUL: state_nxt = ST_T_ADD;
      ST_T_ADD: begin
        cur_term_nxt[k_r] = cur_new;
        neg_nxt   = t_val[T_W-1];
        src_nxt   = SUM_W'(t_abs[MAG_W-1:0]);
        state_nxt = ST_SC_LO;
      end
      ST_LAST_SEL: begin
        neg_nxt   = t_val[T_W-1];
        src_nxt   = SUM_W'(t_abs[MAG_W-1:0]);
        state_nxt = ST_SC_LO;
      end
      ST_SC_LO: state_nxt = ST_SC_HI;
      ST_SC_HI: begin
        acc_nxt   = ACC_W'(prod_r);
        state_nxt = ST_SC_ADD;
      end
      ST_SC_ADD: state_nxt = ST_SC_WAIT;
      ST_SC_WAIT: begin
        if (div_rsp.done) begin
          unique case (phase_r)
            PH_GRAD: begin
              grad_nxt[k_r] = grad_val;
              if (k_r == AXIS_W'(NUM_AXES - 1)) begin
                state_nxt = ST_EMIT;
              end else begin
                k_nxt     = k_r + AXIS_W'(1);
                state_nxt = ST_T_MUL;
              end
            end
            PH_LAST: begin
              grad_nxt[k_r] = grad_val;
              if (k_r == AXIS_W'(NUM_AXES - 1)) begin
                src_nxt   = qsum_r;
                phase_nxt = PH_COST;
                state_nxt = ST_SC_LO;
              end else begin
                k_nxt     = k_r + AXIS_W'(1);
                state_nxt = ST_LAST_SEL;
              end
            end
            PH_COST: begin
              cost_nxt  = cost_val;
              state_nxt = ST_EMIT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_grad_nxt  = grad_r;
          if (phase_r == PH_COST) begin
            out_index_nxt = cnt_r;
            out_cost_nxt  = cost_r;
            out_final_nxt = 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
              prev_term_nxt[a] = '0;
            end
            cnt_nxt   = '0;
            qsum_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            out_index_nxt = cnt_r - CNT_W'(1);
            out_cost_nxt  = '0;
            out_final_nxt = 1'b0;
            prev_term_nxt = cur_term_r;
            if (cnt_r < n_eff) begin
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = ST_IDLE;
            end else begin
              k_nxt     = '0;
              phase_nxt = PH_LAST;
              state_nxt = ST_LAST_SEL;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_GRAD;
      k_r         <= '0;
      weight_r    <= '0;
      seg_count_r <= CNT_W'(1);
      cnt_r       <= '0;
      qsum_r      <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        prev_term_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      weight_r    <= weight_nxt;
      seg_count_r <= seg_count_nxt;
      cnt_r       <= cnt_nxt;
      qsum_r      <= qsum_nxt;
      out_valid_r <= out_valid_nxt;
      prev_term_r <= prev_term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_r         <= sq_nxt;
    src_r        <= src_nxt;
    neg_r        <= neg_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    cost_r       <= cost_nxt;
    prev_point_r <= prev_point_nxt;
    delta_r      <= delta_nxt;
    cur_term_r   <= cur_term_nxt;
    grad_r       <= grad_nxt;
    out_index_r  <= out_index_nxt;
    out_grad_r   <= out_grad_nxt;
    out_cost_r   <= out_cost_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_point_index = out_index_r;
  assign out_grad_x      = out_grad_r[0];
  assign out_grad_y      = out_grad_r[1];
  assign out_grad_z      = out_grad_r[2];
  assign out_cost_value  = out_cost_r;
  assign out_final_res   = out_final_r;

endmodule

// File: rtl/core/segvar_div.sv
// Iterative restoring divider by the segment count, several quotient bits per cycle.
module segvar_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  segvar_pkg::div_req_t req,
  output segvar_pkg::div_rsp_t rsp
);
  import segvar_pkg::*;

  logic                 busy_r;
  logic                 busy_nxt;
  logic                 done_r;
  logic                 done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;
  logic [DIV_W-1:0]     work_r;
  logic [DIV_W-1:0]     work_nxt;
  logic [REM_W-1:0]     rem_r;
  logic [REM_W-1:0]     rem_nxt;
  logic [REM_W:0]       div_r;

  // One radix-2 step per bit: shift in the next dividend bit, subtract if it fits
  always_comb begin : div_steps
    logic [REM_W:0]   trial;
    logic [DIV_W-1:0] w;
    logic [REM_W-1:0] r;
    w = work_r;
    r = rem_r;
    trial = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {r, w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (trial >= div_r) begin
        trial = trial - div_r;
        w[0] = 1'b1;
      end
      r = trial[REM_W-1:0];
    end
    work_nxt = w;
    rem_nxt  = r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work_r <= req.dividend;
      rem_r  <= '0;
      div_r  <= (REM_W + 1)'(req.divisor);
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = work_r;

endmodule

// File: rtl/core/segvar_chk.sv
// Port-level checker for the segment variance block, bound to the top level.
module segvar_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic        [segvar_pkg::CNT_W-1:0]  out_point_index,
  input logic signed [segvar_pkg::GRAD_W-1:0] out_grad_x,
  input logic signed [segvar_pkg::GRAD_W-1:0] out_grad_y,
  input logic signed [segvar_pkg::GRAD_W-1:0] out_grad_z,
  input logic        [segvar_pkg::COST_W-1:0] out_cost_value,
  input logic                                 out_final_res
);
  import segvar_pkg::*;

  // result register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_index)
      && $stable(out_grad_x) && $stable(out_final_res))
    else $error("stalled result request changed");

  a_cost_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |-> out_cost_value == '0)
    else $error("cost on a non-final result");

  a_final_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |-> out_point_index != '0)
    else $error("final result at point zero");

  // scaled gradients stay well inside the 64-bit range
  a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_grad_x[GRAD_W-1:GRAD_W-3] == 3'b000 || out_grad_x[GRAD_W-1:GRAD_W-3] == 3'b111)
      && (out_grad_y[GRAD_W-1:GRAD_W-3] == 3'b000
          || out_grad_y[GRAD_W-1:GRAD_W-3] == 3'b111)
      && (out_grad_z[GRAD_W-1:GRAD_W-3] == 3'b000
          || out_grad_z[GRAD_W-1:GRAD_W-3] == 3'b111))
    else $error("gradient out of range");

endmodule

bind segment_length_variance_gradient segvar_chk u_segvar_chk (.*);
